// File: rtl/aios_pkg.sv
package aios_pkg;

	// Item kinds carried on the input tuser.
	localparam logic [1:0] FUNC_KEY   = 2'd0;
	localparam logic [1:0] FUNC_READ  = 2'd1;
	localparam logic [1:0] FUNC_WRITE = 2'd2;

	// Decoded port numbers.
	localparam logic [7:0] PORT_INPUTS = 8'd1;
	localparam logic [7:0] PORT_OFFSET = 8'd2;
	localparam logic [7:0] PORT_SHIFT  = 8'd3;
	localparam logic [7:0] PORT_DATA   = 8'd4;
	localparam logic [7:0] PORT_SOUND2 = 8'd5;
	localparam logic [7:0] PORT_WDOG   = 8'd6;

	// Key numbers.
	localparam logic [2:0] KEY_COIN  = 3'd0;
	localparam logic [2:0] KEY_START = 3'd1;
	localparam logic [2:0] KEY_FIRE  = 3'd2;
	localparam logic [2:0] KEY_LEFT  = 3'd3;
	localparam logic [2:0] KEY_RIGHT = 3'd4;

	localparam int NUM_KEYS    = 5;
	localparam int NUM_LATCHES = 2;

	// Bit positions in the port 1 read byte.
	localparam int RD_COIN_BIT  = 0;
	localparam int RD_START_BIT = 2;
	localparam int RD_FIRE_BIT  = 4;
	localparam int RD_LEFT_BIT  = 5;
	localparam int RD_RIGHT_BIT = 6;

	typedef struct packed {
		logic [7:0] wdata;
		logic [7:0] port;
		logic       pressed;
		logic [2:0] key_id;
		logic [1:0] func;
	} item_t;

	typedef struct packed {
		logic       unhandled;
		logic [7:0] rdata;
	} result_t;

endpackage

// File: rtl/aios_exec.sv
module aios_exec import aios_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    fire,
	input  item_t   item,
	output result_t result
);

	logic [15:0]            shift_word_q;
	logic [2:0]             shift_offset_q;
	logic [NUM_KEYS-1:0]    key_levels_q;
	logic [NUM_LATCHES-1:0] press_latches_q;

	logic [15:0]            shift_word_d;
	logic [2:0]             shift_offset_d;
	logic [NUM_KEYS-1:0]    key_levels_d;
	logic [NUM_LATCHES-1:0] press_latches_d;
	logic [23:0]            shifted;
	logic                   key_valid;
	logic                   key_held;

	// Barrel shift for the port 3 read window.
	assign shifted   = {8'h00, shift_word_q} << shift_offset_q;
	assign key_valid = item.key_id <= KEY_RIGHT;
	assign key_held  = key_valid && key_levels_q[item.key_id];

	// Result and next state for the item in the stage.
	always_comb begin
		shift_word_d    = shift_word_q;
		shift_offset_d  = shift_offset_q;
		key_levels_d    = key_levels_q;
		press_latches_d = press_latches_q;
		result          = '0;
		case (item.func)
			FUNC_KEY: begin
				if (key_valid) begin
					if (item.pressed && !key_held && item.key_id <= KEY_START) begin
						press_latches_d[item.key_id[0]] = 1'b1;
					end
					key_levels_d[item.key_id] = item.pressed;
				end
			end
			FUNC_READ: begin
				case (item.port)
					PORT_INPUTS: begin
						result.rdata[RD_COIN_BIT]  = press_latches_q[KEY_COIN[0]];
						result.rdata[RD_START_BIT] = press_latches_q[KEY_START[0]];
						result.rdata[RD_FIRE_BIT]  = key_levels_q[KEY_FIRE];
						result.rdata[RD_LEFT_BIT]  = key_levels_q[KEY_LEFT];
						result.rdata[RD_RIGHT_BIT] = key_levels_q[KEY_RIGHT];
						press_latches_d            = '0;
					end
					PORT_OFFSET: result.rdata = '0;
					PORT_SHIFT:  result.rdata = shifted[15:8];
					default:     result.unhandled = 1'b1;
				endcase
			end
			FUNC_WRITE: begin
				case (item.port)
					PORT_OFFSET: shift_offset_d = item.wdata[2:0];
					PORT_DATA:   shift_word_d   = {item.wdata, shift_word_q[15:8]};
					PORT_SHIFT, PORT_SOUND2, PORT_WDOG: begin
						// Port 3, sound and watchdog writes are taken and dropped.
					end
					default:     result.unhandled = 1'b1;
				endcase
			end
			default: begin
			end
		endcase
	end

	// Board state, updated once per item as it leaves the stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_word_q    <= '0;
			shift_offset_q  <= '0;
			key_levels_q    <= '0;
			press_latches_q <= '0;
		end else if (fire) begin
			shift_word_q    <= shift_word_d;
			shift_offset_q  <= shift_offset_d;
			key_levels_q    <= key_levels_d;
			press_latches_q <= press_latches_d;
		end
	end

endmodule

// File: rtl/arcade_io_ports_with_shifter.sv
// Each item's result is formed from the input register and held in the
// result register. One item per cycle while the output is not stalled;
// the two registers form a two-stage pipeline; state updates once per item.
// Reset (arst_n low) empties both stages, zeroes the shift word and offset,
// releases all keys and clears the coin and start press latches.
module arcade_io_ports_with_shifter import aios_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // key_id[2:0], pressed[3], port[11:4], wdata[19:12], zero
	input  logic [1:0]  s_tuser,  // func[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // rdata[7:0]
	output logic        m_tuser   // unhandled[0]
);

	logic    valid_s1;
	item_t   item_s1;
	logic    valid_s2;
	result_t result_s2;
	result_t result;
	logic    advance;

	// The item moves on when the result register is free or being emptied.
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.func    <= s_tuser;
			item_s1.key_id  <= s_tdata[2:0];
			item_s1.pressed <= s_tdata[3];
			item_s1.port    <= s_tdata[11:4];
			item_s1.wdata   <= s_tdata[19:12];
		end
	end

	aios_exec u_exec (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.item   (item_s1),
		.result (result)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = result_s2.rdata;
	assign m_tuser  = result_s2.unhandled;

endmodule

// File: rtl/aios_checker.sv
module aios_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata,
	input logic        m_tuser
);

	// A stalled result holds its value until it is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// An undecoded access never returns read data.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == 8'h00)
		else $error("unhandled result carries data");

	// With the output side ready, the pipeline never stalls its input.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input stalled with output ready");

	// Leaving reset, no result is pending.
	assert property (@(posedge clk)
		$rose(arst_n) |-> !m_tvalid)
		else $error("result pending after reset");

endmodule

bind arcade_io_ports_with_shifter aios_checker u_aios_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// File: test/tb_arcade_io_ports_with_shifter.sv
`timescale 1ns / 100ps

module tb_arcade_io_ports_with_shifter;
	import aios_pkg::*;

	// Codes that the package leaves out: the unused item kind and some
	// undecoded keys and ports.
	localparam logic [1:0] FUNC_NONE     = 2'd3;
	localparam logic [2:0] KEY_UNUSED_LO = 3'd5;
	localparam logic [2:0] KEY_UNUSED_HI = 3'd7;
	localparam logic [7:0] PORT_NONE_LO  = 8'd0;
	localparam logic [7:0] PORT_NONE_HI  = 8'd255;

	localparam int RANDOM_ITEMS  = 1900;
	localparam int HOLD_CYCLES   = 300;
	localparam int HOLD_AFTER    = 500;
	localparam int MAX_REPORTS   = 10;
	localparam int TIMEOUT_NS    = 5000000;

	typedef struct {
		item_t   it;
		bit      known;
		result_t want;
	} step_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;
	logic        m_tuser;

	// Item on the input bus and, for table rows, its hand-written result.
	item_t   cur_item;
	bit      cur_known;
	result_t cur_want;

	// Shadow copy of the block state, advanced once per input transfer.
	logic [15:0]          shadow_word    = '0;
	logic [2:0]           shadow_offset  = '0;
	logic [NUM_KEYS-1:0]  shadow_keys    = '0;
	logic [NUM_LATCHES-1:0] shadow_latch = '0;

	result_t pending_results[$];
	step_t   directed_steps[$];
	int      mismatches   = 0;
	int      results_seen = 0;
	bit      sender_steady = 0;

	arcade_io_ports_with_shifter DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// Free-running 8 ns clock.
	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// The run is cut short if it ever hangs.
	initial begin
		#TIMEOUT_NS;
		$display("timeout with %0d results outstanding", pending_results.size());
		$display("FAIL");
		$finish;
	end

	// Computes the result of one item and advances the shadow state.
	function automatic result_t port_response(input item_t it);
		result_t r;
		logic [15:0] shifted;
		r = '0;
		case (it.func)
			FUNC_KEY: begin
				if (it.key_id <= KEY_RIGHT) begin
					// Coin and start latch only on a released-to-pressed change.
					if (it.pressed && !shadow_keys[it.key_id] && it.key_id <= KEY_START)
						shadow_latch[it.key_id[0]] = 1'b1;
					shadow_keys[it.key_id] = it.pressed;
				end
			end
			FUNC_READ: begin
				case (it.port)
					PORT_INPUTS: begin
						r.rdata[RD_COIN_BIT]  = shadow_latch[KEY_COIN[0]];
						r.rdata[RD_START_BIT] = shadow_latch[KEY_START[0]];
						r.rdata[RD_FIRE_BIT]  = shadow_keys[KEY_FIRE];
						r.rdata[RD_LEFT_BIT]  = shadow_keys[KEY_LEFT];
						r.rdata[RD_RIGHT_BIT] = shadow_keys[KEY_RIGHT];
						shadow_latch = '0;
					end
					PORT_OFFSET: r.rdata = '0;
					PORT_SHIFT: begin
						shifted = shadow_word << shadow_offset;
						r.rdata = shifted[15:8];
					end
					default: r.unhandled = 1'b1;
				endcase
			end
			FUNC_WRITE: begin
				case (it.port)
					PORT_OFFSET: shadow_offset = it.wdata[2:0];
					PORT_DATA:   shadow_word = {it.wdata, shadow_word[15:8]};
					PORT_SHIFT, PORT_SOUND2, PORT_WDOG: ;
					default: r.unhandled = 1'b1;
				endcase
			end
			default: ;
		endcase
		return r;
	endfunction

	// Idle length: mostly none or short, now and then long.
	function automatic int idle_cycles(input bit steady);
		int pick;
		pick = $urandom_range(0, 99);
		if (steady || pick < 55)
			return 0;
		else if (pick < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(4, 20);
	endfunction

	// Random item, weighted toward the decoded ports and real keys. The flag
	// tells whether the block does anything with it.
	function automatic item_t random_item(output bit counted);
		item_t it;
		int pick;
		it.key_id  = 3'($urandom);
		it.pressed = 1'($urandom);
		it.port    = 8'($urandom);
		it.wdata   = 8'($urandom);
		counted = 1'b1;
		pick = $urandom_range(0, 99);
		if (pick < 25) begin
			it.func = FUNC_KEY;
			if ($urandom_range(0, 9) == 0) begin
				it.key_id = 3'($urandom_range(KEY_UNUSED_LO, KEY_UNUSED_HI));
				counted = 1'b0;
			end else begin
				it.key_id = 3'($urandom_range(KEY_COIN, KEY_RIGHT));
			end
		end else if (pick < 60) begin
			it.func = FUNC_READ;
			pick = $urandom_range(0, 9);
			if (pick < 3)
				it.port = PORT_INPUTS;
			else if (pick < 4)
				it.port = PORT_OFFSET;
			else if (pick < 8)
				it.port = PORT_SHIFT;
		end else if (pick < 95) begin
			it.func = FUNC_WRITE;
			pick = $urandom_range(0, 9);
			if (pick < 4)
				it.port = PORT_DATA;
			else if (pick < 6)
				it.port = PORT_OFFSET;
			else if (pick < 7) begin
				case ($urandom_range(0, 2))
					0: it.port = PORT_SHIFT;
					1: it.port = PORT_SOUND2;
					default: it.port = PORT_WDOG;
				endcase
			end
		end else begin
			it.func = FUNC_NONE;
			counted = 1'b0;
		end
		return it;
	endfunction

	function automatic void add_row(input logic [1:0] func, input logic [2:0] key_id,
		input logic pressed, input logic [7:0] port, input logic [7:0] wdata,
		input bit known, input logic [7:0] rdata, input logic unhandled);
		step_t s;
		s.it.func      = func;
		s.it.key_id    = key_id;
		s.it.pressed   = pressed;
		s.it.port      = port;
		s.it.wdata     = wdata;
		s.known        = known;
		s.want.rdata     = rdata;
		s.want.unhandled = unhandled;
		directed_steps.push_back(s);
	endfunction

	// Offers one item after a random gap and waits for its transfer.
	// Entered and left at a falling edge.
	task automatic send_item(input item_t it, input bit known, input result_t want);
		int gap;
		gap = idle_cycles(sender_steady);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid  <= 1'b1;
		s_tdata   <= {4'b0, it.wdata, it.port, it.pressed, it.key_id};
		s_tuser   <= it.func;
		cur_item  <= it;
		cur_known <= known;
		cur_want  <= want;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic report(input string what, input logic [7:0] want, input logic [7:0] got);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%0t: %s mismatch, expected %02h, got %02h", $realtime, what, want, got);
	endtask

	// Checks each output transfer against the oldest expectation, then
	// records the expectation of each input transfer.
	always @(posedge clk) begin
		result_t want;
		result_t got;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (pending_results.size() == 0) begin
					report("unexpected result, rdata", 8'h00, m_tdata);
				end else begin
					want = pending_results.pop_front();
					if (m_tdata !== want.rdata)
						report("rdata", want.rdata, m_tdata);
					if (m_tuser !== want.unhandled)
						report("unhandled", {7'b0, want.unhandled}, {7'b0, m_tuser});
				end
			end
			if (s_tvalid && s_tready) begin
				got = port_response(cur_item);
				pending_results.push_back(cur_known ? cur_want : got);
			end
		end
	end

	// Output side: random ready and stall runs, a steady stretch now and
	// then, and one long hold-off that backs the block up.
	initial begin
		int len;
		bit held_off;
		held_off = 1'b0;
		m_tready = 1'b0;
		wait (arst_n);
		@(negedge clk);
		forever begin
			if (!held_off && results_seen >= HOLD_AFTER) begin
				held_off = 1'b1;
				m_tready <= 1'b0;
				len = HOLD_CYCLES;
			end else if ($urandom_range(0, 19) == 0) begin
				m_tready <= 1'b1;
				len = $urandom_range(20, 80);
			end else if ($urandom_range(0, 2) == 0) begin
				m_tready <= 1'b0;
				len = idle_cycles(1'b0) + 1;
			end else begin
				m_tready <= 1'b1;
				len = $urandom_range(1, 8);
			end
			repeat (len) @(negedge clk);
		end
	end

	// Reset, the directed table, the random items, then the drain.
	initial begin
		item_t   it;
		result_t none;
		bit      counted;
		int      done;
		none      = '0;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = FUNC_KEY;
		cur_item  = '0;
		cur_known = 1'b0;
		cur_want  = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reads just after reset, and reads and writes of undecoded ports at both ends.
		add_row(FUNC_READ,  KEY_COIN,      1'b0, PORT_INPUTS,  8'h00, 1, 8'h00, 1'b0);
		add_row(FUNC_READ,  KEY_COIN,      1'b0, PORT_SHIFT,   8'h00, 1, 8'h00, 1'b0);
		add_row(FUNC_READ,  KEY_COIN,      1'b0, PORT_OFFSET,  8'h00, 1, 8'h00, 1'b0);
		add_row(FUNC_READ,  KEY_UNUSED_HI, 1'b1, PORT_NONE_LO, 8'hFF, 1, 8'h00, 1'b1);
		add_row(FUNC_READ,  KEY_COIN,      1'b0, PORT_NONE_HI, 8'h00, 1, 8'h00, 1'b1);
		add_row(FUNC_WRITE, KEY_COIN,      1'b0, PORT_NONE_LO, 8'hFF, 1, 8'h00, 1'b1);
		add_row(FUNC_WRITE, KEY_UNUSED_HI, 1'b1, PORT_NONE_HI, 8'h00, 1, 8'h00, 1'b1);
		// Shift register: two bytes in, then reads at the largest and zero offset.
		add_row(FUNC_WRITE, KEY_COIN,      1'b0, PORT_DATA,    8'hFF, 1, 8'h00, 1'b0);
		add_row(FUNC_WRITE, KEY_COIN,      1'b0, PORT_DATA,    8'hA5, 1, 8'h00, 1'b0);
		add_row(FUNC_READ,  KEY_COIN,      1'b0, PORT_SHIFT,   8'h00, 1, 8'hA5, 1'b0);
		add_row(FUNC_WRITE, KEY_COIN,      1'b0, PORT_OFFSET,  8'hFF, 1, 8'h00, 1'b0);
		add_row(FUNC_READ,  KEY_COIN,      1'b0, PORT_SHIFT,   8'h00, 0, 8'h00, 1'b0);
		// Offset keeps only its low three bits.
		add_row(FUNC_WRITE, KEY_COIN,      1'b0, PORT_OFFSET,  8'hF8, 1, 8'h00, 1'b0);
		add_row(FUNC_READ,  KEY_COIN,      1'b0, PORT_SHIFT,   8'h00, 1, 8'hA5, 1'b0);
		// Key presses, a repeated press and a key that does not exist.
		add_row(FUNC_KEY,   KEY_COIN,      1'b1, PORT_INPUTS,  8'h00, 1, 8'h00, 1'b0);
		add_row(FUNC_KEY,   KEY_COIN,      1'b1, PORT_INPUTS,  8'h00, 1, 8'h00, 1'b0);
		add_row(FUNC_KEY,   KEY_START,     1'b1, PORT_INPUTS,  8'h00, 1, 8'h00, 1'b0);
		add_row(FUNC_KEY,   KEY_FIRE,      1'b1, PORT_INPUTS,  8'h00, 1, 8'h00, 1'b0);
		add_row(FUNC_KEY,   KEY_LEFT,      1'b1, PORT_INPUTS,  8'h00, 1, 8'h00, 1'b0);
		add_row(FUNC_KEY,   KEY_RIGHT,     1'b1, PORT_INPUTS,  8'h00, 1, 8'h00, 1'b0);
		add_row(FUNC_KEY,   KEY_UNUSED_HI, 1'b1, PORT_NONE_HI, 8'hFF, 1, 8'h00, 1'b0);
		// The first read clears the latches, the second shows levels only.
		add_row(FUNC_READ,  KEY_COIN,      1'b0, PORT_INPUTS,  8'h00, 0, 8'h00, 1'b0);
		add_row(FUNC_READ,  KEY_COIN,      1'b0, PORT_INPUTS,  8'h00, 0, 8'h00, 1'b0);
		add_row(FUNC_KEY,   KEY_COIN,      1'b0, PORT_INPUTS,  8'h00, 1, 8'h00, 1'b0);
		add_row(FUNC_KEY,   KEY_RIGHT,     1'b0, PORT_INPUTS,  8'h00, 1, 8'h00, 1'b0);
		// Unused item kind, and writes that are taken but do nothing.
		add_row(FUNC_NONE,  KEY_UNUSED_HI, 1'b1, PORT_NONE_HI, 8'hFF, 1, 8'h00, 1'b0);
		add_row(FUNC_WRITE, KEY_COIN,      1'b0, PORT_SHIFT,   8'h5A, 1, 8'h00, 1'b0);
		add_row(FUNC_WRITE, KEY_COIN,      1'b0, PORT_SOUND2,  8'hFF, 1, 8'h00, 1'b0);
		add_row(FUNC_WRITE, KEY_COIN,      1'b0, PORT_WDOG,    8'h00, 1, 8'h00, 1'b0);
		add_row(FUNC_READ,  KEY_COIN,      1'b0, PORT_INPUTS,  8'h00, 0, 8'h00, 1'b0);

		foreach (directed_steps[i])
			send_item(directed_steps[i].it, directed_steps[i].known, directed_steps[i].want);

		// Random items; ignored ones do not count toward the total.
		done = 0;
		while (done < RANDOM_ITEMS) begin
			if (done % 150 == 0)
				sender_steady = ($urandom_range(0, 3) == 0);
			it = random_item(counted);
			send_item(it, 1'b0, none);
			if (counted)
				done++;
		end
		s_tvalid <= 1'b0;

		// Drain, then give the pipeline time to show any stray result.
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// File: arcade_io_ports_with_shifter.f
rtl/aios_pkg.sv
rtl/aios_exec.sv
rtl/arcade_io_ports_with_shifter.sv
rtl/aios_checker.sv
test/tb_arcade_io_ports_with_shifter.sv
